// File: rtl/epv_pkg.sv
// Package with the types, constants and codes of the encoder position and velocity core.
`timescale 1ns / 1ps

package epv_pkg;

  localparam int ROT_BITS = 24;
  localparam int CPR_W    = 15;
  localparam int RATE_W   = 16;
  localparam int RAW_W    = 16;
  localparam int TICK_W   = 40;
  localparam int OUT_W    = 48;
  localparam int ACC_W    = 72;
  localparam int K_W      = 31;
  localparam int CFG_W    = 16;

  localparam int TMUL_N = CPR_W;
  localparam int KMUL_N = K_W;
  localparam int DIV_N  = ACC_W;
  localparam int CNT_W  = $clog2(DIV_N);

  localparam logic [K_W-1:0] K_ANGLE = K_W'(360 * 256);
  localparam logic [K_W-1:0] K_SPEED = K_W'(60 * 256);

  localparam logic [CPR_W-1:0]  CPR_RESET  = CPR_W'(1024);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

  typedef enum logic [1:0] {
    OP_POS = 2'd0,
    OP_OVF = 2'd1,
    OP_VEL = 2'd2,
    OP_RST = 2'd3
  } op_t;

  typedef enum logic {
    CFG_CPR  = 1'b0,
    CFG_RATE = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_POS_LOAD,
    UOP_OVF,
    UOP_RST,
    UOP_VEL,
    UOP_MUL,
    UOP_ADDV,
    UOP_TICKS,
    UOP_ABS,
    UOP_LOADK,
    UOP_DIV,
    UOP_FIN
  } uop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TMUL,
    S_ADDV,
    S_TICKS,
    S_ABS,
    S_LOADK,
    S_KMUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [RAW_W-1:0] counter_value;
    logic             direction;
  } in_data_t;

  typedef struct packed {
    logic                     counter_clear;
    logic signed [TICK_W-1:0] total_ticks;
    logic signed [OUT_W-1:0]  angle_deg_q8;
    logic signed [OUT_W-1:0]  speed_rpm_q8;
  } out_data_t;

  typedef struct packed {
    logic [CPR_W-1:0]  cpr;
    logic [RATE_W-1:0] rate;
  } cfg_t;

  typedef struct packed {
    uop_t uop;
    logic in_ready;
    logic out_load;
  } ctl_t;

endpackage

// File: rtl/epv_seq.sv
// Sequencer that steps the shared adder through multiply, divide and update phases.
`timescale 1ns / 1ps

module epv_seq import epv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic       out_free,
  output ctl_t       ctl
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ctl.uop      = UOP_NONE;
    ctl.in_ready = 1'b0;
    ctl.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid) begin
          case (op_t'(in_op))
            OP_POS: begin
              ctl.uop   = UOP_POS_LOAD;
              state_nxt = S_TMUL;
              cnt_nxt   = CNT_W'(TMUL_N - 1);
            end
            OP_OVF: begin
              ctl.uop   = UOP_OVF;
              state_nxt = S_DONE;
            end
            OP_VEL: begin
              ctl.uop   = UOP_VEL;
              state_nxt = S_ABS;
            end
            default: begin
              ctl.uop   = UOP_RST;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_TMUL: begin
        ctl.uop = UOP_MUL;
        if (cnt_r == '0) begin
          state_nxt = S_ADDV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ADDV: begin
        ctl.uop   = UOP_ADDV;
        state_nxt = S_TICKS;
      end
      S_TICKS: begin
        ctl.uop   = UOP_TICKS;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        ctl.uop   = UOP_ABS;
        state_nxt = S_LOADK;
      end
      S_LOADK: begin
        ctl.uop   = UOP_LOADK;
        state_nxt = S_KMUL;
        cnt_nxt   = CNT_W'(KMUL_N - 1);
      end
      S_KMUL: begin
        ctl.uop = UOP_MUL;
        if (cnt_r == '0) begin
          state_nxt = S_DIV;
          cnt_nxt   = CNT_W'(DIV_N - 1);
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DIV: begin
        ctl.uop = UOP_DIV;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        ctl.uop   = UOP_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/epv_datapath.sv
// Position, velocity and scaling state around one shared 72-bit add and subtract unit.
`timescale 1ns / 1ps

module epv_datapath import epv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_t      ctl,
  input  cfg_t      cfg,
  input  in_data_t  in_data,
  output out_data_t res
);

  logic [ROT_BITS-1:0] rot_r, rot_nxt;
  logic [TICK_W-1:0]   cur_r, cur_nxt;
  logic [TICK_W-1:0]   prev_r, prev_nxt;
  logic [OUT_W-1:0]    angle_r, angle_nxt;
  logic [OUT_W-1:0]    speed_r, speed_nxt;
  logic                clear_r, clear_nxt;

  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ACC_W-1:0]    mcand_r, mcand_nxt;
  logic [K_W-1:0]      mplier_r, mplier_nxt;
  logic [CPR_W-1:0]    rem_r, rem_nxt;
  logic [RAW_W-1:0]    v_r, v_nxt;
  logic                neg_r, neg_nxt;
  logic                tgt_r, tgt_nxt;

  logic [CPR_W-1:0]    dcpr;
  logic [K_W-1:0]      k_speed;
  logic [ACC_W-1:0]    add_a, add_b, sum;
  logic                add_sub;
  logic [CPR_W:0]      rem_shift;
  logic [ROT_BITS-1:0] rot_pos;
  logic                wrap_lo, wrap_hi;
  logic                over;
  logic [ACC_W-1:0]    sat;

  assign dcpr    = (cfg.cpr == '0) ? CPR_W'(1) : cfg.cpr;
  assign k_speed = K_W'(cfg.rate) * K_SPEED;

  assign wrap_lo = $signed({in_data.counter_value[RAW_W-1], in_data.counter_value})
                   < -$signed({2'b00, dcpr});
  assign wrap_hi = $signed({in_data.counter_value[RAW_W-1], in_data.counter_value})
                   > $signed({2'b00, dcpr});

  always_comb begin
    rot_pos = rot_r;
    if (wrap_lo) begin
      rot_pos = rot_r - 1'b1;
    end else if (wrap_hi) begin
      rot_pos = rot_r + 1'b1;
    end
  end

  assign rem_shift = {rem_r, acc_r[ACC_W-1]};

  always_comb begin
    if (neg_r) begin
      over = (|acc_r[ACC_W-1:OUT_W]) | (acc_r[OUT_W-1] & (|acc_r[OUT_W-2:0]));
    end else begin
      over = |acc_r[ACC_W-1:OUT_W-1];
    end
    if (!over) begin
      sat = acc_r;
    end else if (neg_r) begin
      sat = ACC_W'(1) << (OUT_W - 1);
    end else begin
      sat = (ACC_W'(1) << (OUT_W - 1)) - 1'b1;
    end
  end

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (ctl.uop)
      UOP_VEL: begin
        add_a   = {{(ACC_W-TICK_W){cur_r[TICK_W-1]}}, cur_r};
        add_b   = {{(ACC_W-TICK_W){prev_r[TICK_W-1]}}, prev_r};
        add_sub = 1'b1;
      end
      UOP_MUL: begin
        add_a = acc_r;
        add_b = mcand_r;
      end
      UOP_ADDV: begin
        add_a = acc_r;
        add_b = {{(ACC_W-RAW_W){v_r[RAW_W-1]}}, v_r};
      end
      UOP_ABS: begin
        add_b   = acc_r;
        add_sub = acc_r[ACC_W-1];
      end
      UOP_DIV: begin
        add_a   = ACC_W'(rem_shift);
        add_b   = ACC_W'(dcpr);
        add_sub = 1'b1;
      end
      UOP_FIN: begin
        add_b   = sat;
        add_sub = neg_r;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign sum = add_a + (add_b ^ {ACC_W{add_sub}}) + ACC_W'(add_sub);

  always_comb begin
    rot_nxt    = rot_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    angle_nxt  = angle_r;
    speed_nxt  = speed_r;
    clear_nxt  = clear_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    v_nxt      = v_r;
    neg_nxt    = neg_r;
    tgt_nxt    = tgt_r;
    case (ctl.uop)
      UOP_POS_LOAD: begin
        v_nxt      = in_data.counter_value;
        rot_nxt    = rot_pos;
        clear_nxt  = wrap_lo | wrap_hi;
        tgt_nxt    = 1'b0;
        acc_nxt    = '0;
        mcand_nxt  = {{(ACC_W-ROT_BITS){rot_pos[ROT_BITS-1]}}, rot_pos};
        mplier_nxt = K_W'(dcpr);
      end
      UOP_OVF: begin
        rot_nxt   = in_data.direction ? rot_r - 1'b1 : rot_r + 1'b1;
        clear_nxt = 1'b0;
      end
      UOP_RST: begin
        rot_nxt   = '0;
        prev_nxt  = '0;
        angle_nxt = '0;
        clear_nxt = 1'b1;
      end
      UOP_VEL: begin
        acc_nxt   = sum;
        prev_nxt  = cur_r;
        clear_nxt = 1'b0;
        tgt_nxt   = 1'b1;
      end
      UOP_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = sum;
        end
        mcand_nxt  = {mcand_r[ACC_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[K_W-1:1]};
      end
      UOP_ADDV: begin
        acc_nxt = sum;
      end
      UOP_TICKS: begin
        cur_nxt = acc_r[TICK_W-1:0];
        acc_nxt = {{(ACC_W-TICK_W){acc_r[TICK_W-1]}}, acc_r[TICK_W-1:0]};
      end
      UOP_ABS: begin
        neg_nxt = acc_r[ACC_W-1];
        acc_nxt = sum;
      end
      UOP_LOADK: begin
        mcand_nxt  = acc_r;
        acc_nxt    = '0;
        mplier_nxt = tgt_r ? k_speed : K_ANGLE;
        rem_nxt    = '0;
      end
      UOP_DIV: begin
        if (!sum[ACC_W-1]) begin
          rem_nxt = sum[CPR_W-1:0];
          acc_nxt = {acc_r[ACC_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift[CPR_W-1:0];
          acc_nxt = {acc_r[ACC_W-2:0], 1'b0};
        end
      end
      UOP_FIN: begin
        if (tgt_r) begin
          speed_nxt = sum[OUT_W-1:0];
        end else begin
          angle_nxt = sum[OUT_W-1:0];
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r   <= '0;
      cur_r   <= '0;
      prev_r  <= '0;
      angle_r <= '0;
      speed_r <= '0;
      clear_r <= 1'b0;
    end else begin
      rot_r   <= rot_nxt;
      cur_r   <= cur_nxt;
      prev_r  <= prev_nxt;
      angle_r <= angle_nxt;
      speed_r <= speed_nxt;
      clear_r <= clear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    v_r      <= v_nxt;
    neg_r    <= neg_nxt;
    tgt_r    <= tgt_nxt;
  end

  assign res.counter_clear = clear_r;
  assign res.total_ticks   = cur_r;
  assign res.angle_deg_q8  = angle_r;
  assign res.speed_rpm_q8  = speed_r;

endmodule

// File: rtl/encoder_position_velocity_core.sv
// Top level of the encoder position and velocity core with configuration and output registers.
`timescale 1ns / 1ps

// One transaction is taken at a time through a single 72-bit adder under a small sequencer.
// For a position sample, 15 steps multiply the rotation count by counts per revolution,
// 31 steps form the scaled product and 72 restoring divide steps divide by counts per
// revolution. The result sits in an output register, so the next transaction is taken while
// it waits to be read.

module encoder_position_velocity_core import epv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_data_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_data_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  ctl_t              ctl;
  cfg_t              cfg;
  out_data_t         res;
  logic [CPR_W-1:0]  cpr_r;
  logic [RATE_W-1:0] rate_r;
  logic              out_valid_r;
  out_data_t         out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r  <= CPR_RESET;
      rate_r <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CPR:  cpr_r  <= cfg_wdata[CPR_W-1:0];
        CFG_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
        default:  cpr_r  <= cpr_r;
      endcase
    end
  end

  assign cfg.cpr  = cpr_r;
  assign cfg.rate = rate_r;

  epv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .out_free (!out_valid_r || out_ready),
    .ctl      (ctl)
  );

  epv_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .cfg     (cfg),
    .in_data (in_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r <= res;
    end
  end

  assign in_ready  = ctl.in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/epv_checker.sv
// Port-level assertions for the encoder position and velocity core and their binding.
`timescale 1ns / 1ps

module epv_checker import epv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_data_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_data_t out_data
);

  // A result that is not taken stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // The core works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // A new result only appears after a transaction has been worked on.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in progress");

endmodule

bind encoder_position_velocity_core epv_checker u_epv_checker (.*);

// File: dv/epv_result_check.sv
// Checker that predicts and compares every result of the encoder position and velocity core.
`timescale 1ns / 1ps

module epv_result_check import epv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_data_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_data_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               pending,
  output int               fail_count
);

  logic [CPR_W-1:0]         cpr_reg;
  logic [RATE_W-1:0]        rate_reg;
  logic [ROT_BITS-1:0]      rot_cnt;
  logic signed [TICK_W-1:0] ticks_now;
  logic signed [TICK_W-1:0] ticks_last_vel;
  logic signed [OUT_W-1:0]  angle_now;
  logic signed [OUT_W-1:0]  speed_now;
  out_data_t                awaited_results[$];
  int                       mismatch_cnt = 0;

  assign fail_count = mismatch_cnt;

  // Magnitude times k over d, truncated toward zero and clamped to the signed 48-bit range.
  function automatic logic signed [OUT_W-1:0] scale_q8(logic signed [TICK_W:0] num,
                                                      logic [K_W-1:0] k, longint d);
    logic [TICK_W:0] mag;
    logic [79:0]     quo;
    logic [79:0]     lim;
    mag = num[TICK_W] ? -num : num;
    quo = (80'(mag) * 80'(k)) / 80'(d);
    lim = num[TICK_W] ? (80'(1) << (OUT_W - 1)) : (80'(1) << (OUT_W - 1)) - 80'(1);
    if (quo > lim) quo = lim;
    return num[TICK_W] ? OUT_W'(-quo) : OUT_W'(quo);
  endfunction

  function automatic out_data_t predict_result(in_data_t item);
    int                       reading;
    longint                   c;
    longint                   turns;
    logic signed [TICK_W:0]   delta;
    logic [K_W-1:0]           k_speed;
    out_data_t                r;
    reading = $signed(item.counter_value);
    c = (cpr_reg == '0) ? 1 : cpr_reg;
    r.counter_clear = 1'b0;
    case (op_t'(item.operation))
      OP_POS: begin
        if (reading < -c) begin
          rot_cnt = rot_cnt - 1'b1;
          r.counter_clear = 1'b1;
        end else if (reading > c) begin
          rot_cnt = rot_cnt + 1'b1;
          r.counter_clear = 1'b1;
        end
        turns = $signed(rot_cnt);
        ticks_now = TICK_W'(turns * c + reading);
        angle_now = scale_q8(ticks_now, K_ANGLE, c);
      end
      OP_OVF: begin
        rot_cnt = item.direction ? rot_cnt - 1'b1 : rot_cnt + 1'b1;
      end
      OP_VEL: begin
        delta = ticks_now - ticks_last_vel;
        ticks_last_vel = ticks_now;
        k_speed = rate_reg * K_SPEED;
        speed_now = scale_q8(delta, k_speed, c);
      end
      OP_RST: begin
        rot_cnt = '0;
        ticks_last_vel = '0;
        angle_now = '0;
        r.counter_clear = 1'b1;
      end
      default: ;
    endcase
    r.total_ticks  = ticks_now;
    r.angle_deg_q8 = angle_now;
    r.speed_rpm_q8 = speed_now;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_cnt < 100) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : track
    out_data_t want;
    if (!rst_n) begin
      cpr_reg = CPR_RESET;
      rate_reg = RATE_RESET;
      rot_cnt = '0;
      ticks_now = '0;
      ticks_last_vel = '0;
      angle_now = '0;
      speed_now = '0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CPR:  cpr_reg = cfg_wdata[CPR_W-1:0];
          CFG_RATE: rate_reg = cfg_wdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(out_data.total_ticks), 64'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.counter_clear !== want.counter_clear)
            report_mismatch("counter_clear", 64'(out_data.counter_clear),
                            64'(want.counter_clear));
          if (out_data.total_ticks !== want.total_ticks)
            report_mismatch("total_ticks", 64'(out_data.total_ticks), 64'(want.total_ticks));
          if (out_data.angle_deg_q8 !== want.angle_deg_q8)
            report_mismatch("angle_deg_q8", 64'(out_data.angle_deg_q8),
                            64'(want.angle_deg_q8));
          if (out_data.speed_rpm_q8 !== want.speed_rpm_q8)
            report_mismatch("speed_rpm_q8", 64'(out_data.speed_rpm_q8),
                            64'(want.speed_rpm_q8));
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(predict_result(in_data));
      end
    end
    pending <= awaited_results.size();
  end

endmodule

// File: dv/tb_encoder_position_velocity_core.sv
// Testbench top that drives stimulus into the encoder position and velocity core and gives the verdict.
`timescale 1ns / 1ps

module tb_encoder_position_velocity_core;
  import epv_pkg::*;

  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_GAP         = 12;
  localparam int CYCLE_LIMIT     = 1_500_000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_data_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_data_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               pending;
  int               fail_count;
  bit               calm = 1'b0;
  bit               squeeze_req = 1'b0;
  logic             rx_hold;
  int               cpr_now = 1024;
  int unsigned      cycle_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  encoder_position_velocity_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  epv_result_check result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  function automatic in_data_t mk(op_t op, logic [RAW_W-1:0] raw, logic dir);
    in_data_t d;
    d.operation     = op;
    d.counter_value = raw;
    d.direction     = dir;
    return d;
  endfunction

  // Mostly position samples, many of them close to the wrap threshold.
  function automatic in_data_t pick_item(int c);
    in_data_t d;
    int       roll;
    int       v;
    roll = $urandom_range(0, 99);
    d.counter_value = RAW_W'($urandom);
    d.direction     = 1'($urandom);
    if (roll < 55) begin
      d.operation = OP_POS;
      case ($urandom_range(0, 2))
        0: begin
          v = c + $urandom_range(0, 4) - 2;
          if ($urandom_range(0, 1)) v = -v;
          d.counter_value = RAW_W'(v);
        end
        1: begin
          v = $urandom_range(0, 2 * c) - c;
          d.counter_value = RAW_W'(v);
        end
        default: ;
      endcase
    end else if (roll < 75) begin
      d.operation = OP_VEL;
    end else if (roll < 93) begin
      d.operation = OP_OVF;
    end else begin
      d.operation = OP_RST;
    end
    return d;
  endfunction

  task automatic send_item(in_data_t item);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle(int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] cpr_word, logic [CFG_W-1:0] rate_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CPR;
    cfg_wdata <= cpr_word;
    @(posedge clk);
    cfg_index <= CFG_RATE;
    cfg_wdata <= rate_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    cpr_now = (cpr_word[CPR_W-1:0] == '0) ? 1 : int'(cpr_word[CPR_W-1:0]);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : hold_off
    rx_hold <= 1'b0;
    forever begin
      wait (squeeze_req);
      squeeze_req = 1'b0;
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  initial begin : receiver
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      while (rx_hold) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] cpr_word;
    logic [CFG_W-1:0] rate_word;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_CPR;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of the registers: threshold edges, extremes of the reading, every operation.
    send_item(mk(OP_POS, 16'd0, 1'b0));
    send_item(mk(OP_POS, 16'd1024, 1'b1));
    send_item(mk(OP_POS, 16'd1025, 1'b0));
    send_item(mk(OP_VEL, 16'hFFFF, 1'b1));
    send_item(mk(OP_POS, 16'hFBFF, 1'b0));
    send_item(mk(OP_POS, 16'hFC00, 1'b0));
    send_item(mk(OP_POS, 16'h7FFF, 1'b1));
    send_item(mk(OP_POS, 16'h8000, 1'b0));
    send_item(mk(OP_POS, 16'hFFFF, 1'b1));
    send_item(mk(OP_VEL, 16'h0000, 1'b0));
    send_item(mk(OP_OVF, 16'h5A5A, 1'b0));
    send_item(mk(OP_OVF, 16'hA5A5, 1'b0));
    send_item(mk(OP_OVF, 16'hFFFF, 1'b1));
    send_item(mk(OP_POS, 16'd500, 1'b0));
    send_item(mk(OP_VEL, 16'h1234, 1'b1));
    send_item(mk(OP_RST, 16'hFFFF, 1'b1));
    send_item(mk(OP_VEL, 16'h0000, 1'b0));
    send_item(mk(OP_POS, 16'd7, 1'b0));
    send_item(mk(OP_OVF, 16'h0000, 1'b1));
    send_item(mk(OP_OVF, 16'h0000, 1'b1));
    send_item(mk(OP_POS, 16'hFF00, 1'b0));
    send_item(mk(OP_VEL, 16'h8000, 1'b0));
    send_item(mk(OP_RST, 16'h0000, 1'b0));

    for (int p = 0; p < N_PHASES; p++) begin
      settle(8);
      case (p)
        0: begin
          cpr_word  = 16'd1;
          rate_word = 16'hFFFF;
        end
        1: begin
          cpr_word  = 16'h7FFF;
          rate_word = 16'd1;
        end
        2: begin
          cpr_word  = 16'h8000;
          rate_word = 16'd0;
        end
        3: begin
          cpr_word  = 16'd360;
          rate_word = 16'd1000;
        end
        4: begin
          cpr_word  = CFG_W'($urandom);
          rate_word = CFG_W'($urandom_range(1, 65535));
        end
        5: begin
          cpr_word  = 16'd3;
          rate_word = 16'd50;
        end
        6: begin
          cpr_word  = CFG_W'($urandom_range(1, 32767)) | 16'h8000;
          rate_word = CFG_W'($urandom);
        end
        default: begin
          cpr_word  = CFG_W'(CPR_RESET);
          rate_word = CFG_W'(RATE_RESET);
        end
      endcase
      program_regs(cpr_word, rate_word);
      calm = (p == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((p == 1 || p == 6) && n == 30) squeeze_req = 1'b1;
        send_item(pick_item(cpr_now));
      end
    end

    settle(150);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: encoder_position_velocity_core.f
rtl/epv_pkg.sv
rtl/epv_seq.sv
rtl/epv_datapath.sv
rtl/encoder_position_velocity_core.sv
rtl/epv_checker.sv
dv/epv_result_check.sv
dv/tb_encoder_position_velocity_core.sv
